[src/mmtb_pkg.sv]
// ----------------------------------------------------------------------------
// mmtb_pkg
// Shared types and constants for the transposed-B matrix multiply block.
// ----------------------------------------------------------------------------
package mmtb_pkg;

    // Largest supported matrix dimension (default of the top-level parameter).
    localparam int MMTB_MAX_DIM = 8;

    // Widths fixed by the transaction fields.
    localparam int DIM_W     = 4;
    localparam int IDX_W     = 3;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 40;
    localparam int CFG_IDX_W = 2;

    // Input transaction kinds.
    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_BT = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_RESULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN   = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [ELEM_W-1:0] element;
    } t_in;

    typedef struct packed {
        logic signed [SUM_W-1:0] product;
        logic                    last;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;
        logic wr_bt;
        logic rd;
        logic acc_clr;
        logic push;
        logic push_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

[src/mmtb_ctrl.sv]
// ----------------------------------------------------------------------------
// mmtb_ctrl
// Controller: configuration registers, loop counters and sequencing FSM.
// ----------------------------------------------------------------------------
module mmtb_ctrl #(
    parameter int MAX_DIM = mmtb_pkg::MMTB_MAX_DIM
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  mmtb_pkg::t_in                       i_in,
    output logic                                o_in_stall,
    input  logic                                i_cfg_valid,
    input  logic [mmtb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mmtb_pkg::DIM_W-1:0]          i_cfg_data,
    input  mmtb_pkg::t_dp_status                i_status,
    output mmtb_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_rd_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_rd_addr_b
);
    import mmtb_pkg::*;

    localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_i, n_i, r_j, n_j, r_k, n_k;
    logic [DIM_W-1:0]  r_rows, r_cols, r_inner;
    logic [DIM_W-1:0]  nr, nc, nk;
    logic              last_i, last_j, last_k, load_ok;

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
        f_addr = AW'(row) * AW'(MAX_DIM) + AW'(col);
    endfunction

    // Registers above the largest dimension saturate.
    assign nr = (r_rows  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_rows;
    assign nc = (r_cols  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cols;
    assign nk = (r_inner > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_inner;

    assign last_i = (DIM_W'(r_i) + DIM_W'(1)) == nr;
    assign last_j = (DIM_W'(r_j) + DIM_W'(1)) == nc;
    assign last_k = (DIM_W'(r_k) + DIM_W'(1)) == nk;

    assign load_ok = ({1'b0, i_in.row_index} < DIM_W'(MAX_DIM)) &&
                     ({1'b0, i_in.col_index} < DIM_W'(MAX_DIM));

    assign o_wr_addr   = f_addr(i_in.row_index, i_in.col_index);
    assign o_rd_addr_a = f_addr(IDX_W'(r_i), IDX_W'(r_k));
    assign o_rd_addr_b = f_addr(IDX_W'(r_j), IDX_W'(r_k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_rows  <= DIM_W'(8);
            r_cols  <= DIM_W'(8);
            r_inner <= DIM_W'(8);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROWS_A:      r_rows  <= i_cfg_data;
                    CFG_COLS_RESULT: r_cols  <= i_cfg_data;
                    CFG_INNER_LEN:   r_inner <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.kind)
                        KIND_LOAD_A:  o_cmd.wr_a  = load_ok;
                        KIND_LOAD_BT: o_cmd.wr_bt = load_ok;
                        KIND_COMPUTE: begin
                            if (nr != '0 && nc != '0) begin
                                n_i           = '0;
                                n_j           = '0;
                                n_k           = '0;
                                o_cmd.acc_clr = 1'b1;
                                n_state       = (nk == '0) ? ST_WAIT : ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                o_cmd.rd = 1'b1;
                if (last_k) begin
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            ST_WAIT: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = last_i && last_j;
                    if (last_i && last_j) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = '0;
                        if (last_j) begin
                            n_j = '0;
                            n_i = r_i + CW'(1);
                        end else begin
                            n_j = r_j + CW'(1);
                        end
                        n_state = (nk == '0) ? ST_WAIT : ST_MAC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[src/mmtb_datapath.sv]
// ----------------------------------------------------------------------------
// mmtb_datapath
// Operand stores, multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module mmtb_datapath #(
    parameter int MAX_DIM = mmtb_pkg::MMTB_MAX_DIM
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mmtb_pkg::t_dp_cmd                        i_cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       i_wr_addr,
    input  logic signed [mmtb_pkg::ELEM_W-1:0]       i_wr_data,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       i_rd_addr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       i_rd_addr_b,
    input  logic                                     i_out_stall,
    output mmtb_pkg::t_dp_status                     o_status,
    output logic                                     o_out_valid,
    output mmtb_pkg::t_out                           o_out
);
    import mmtb_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEM_W-1:0]        r_mem_a  [DEPTH];
    logic [ELEM_W-1:0]        r_mem_bt [DEPTH];
    logic [ELEM_W-1:0]        r_a_q, r_b_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic                     r_v1, r_v2, r_out_v;
    t_out                     r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_a_q <= r_mem_a[i_rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_bt) begin
            r_mem_bt[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd) begin
            r_b_q <= r_mem_bt[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd;
            r_v2 <= r_v1;
            if (i_cmd.push) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_a_q) * $signed(r_b_q);
        if (i_cmd.acc_clr || i_cmd.push) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.push) begin
            r_out.product <= r_acc;
            r_out.last    <= i_cmd.push_last;
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = !r_out_v || !i_out_stall;
    assign o_out_valid        = r_out_v;
    assign o_out              = r_out;

endmodule

[src/matrix_multiply_transposed_b.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b
// General matrix multiply C = A * Bt on signed Q8.8 elements with Q24.16 sums.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  --------  ---------  --------------------  ---------------------------------
//  in        sink       i_in_valid/o_in_stall kind, row_index, col_index, element
//  out       source     o_out_valid/i_out_stall product, last
//  cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A load transaction writes its element into the A or Bt store. A compute
// transaction produces rows * cols results; each result takes one
// multiply-accumulate step per inner element through the single shared
// multiplier, then the read and multiply stages drain and the sum moves to the
// output register; with an inner length of zero the cleared sum moves there.
// The input channel is stalled for the whole compute transaction.
// A stalled output holds the sequencer before it posts the next result.
// Reset is synchronous; the stores are not cleared and hold garbage until loaded.
//
module matrix_multiply_transposed_b #(
    parameter int MAX_DIM = mmtb_pkg::MMTB_MAX_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mmtb_pkg::t_in                     i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mmtb_pkg::t_out                    o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmtb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmtb_pkg::DIM_W-1:0]        i_cfg_data
);
    import mmtb_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    t_dp_cmd          cmd;
    t_dp_status       status;
    logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b;

    // The user must issue configuration writes only while the block is idle; the
    // block does not enforce this, and the register file can always take them.
    assign o_cfg_ready = 1'b1;

    // The controller owns the sizes, the i/j/k loop counters and the FSM.
    mmtb_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b)
    );

    // The datapath holds both stores, the multiplier, the accumulator and
    // the output register that decouples the result side from the sequencer.
    mmtb_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_in.element),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[src/mmtb_checker.sv]
// ----------------------------------------------------------------------------
// mmtb_checker
// Port-level checks for the transposed-B matrix multiply block.
// ----------------------------------------------------------------------------
module mmtb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  mmtb_pkg::t_in                     i_in,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  mmtb_pkg::t_out                    o_out
);
    import mmtb_pkg::*;

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in.kind != KIND_COMPUTE
        |=> !$rose(o_out_valid))
        else $error("result appeared after a load");

    // A result that is not the last one is shown only while the compute runs.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_in_stall)
        else $error("non-final result while the input side is open");

    // The input side reopens only together with the final result.
    a_reopen_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_out.last)
        else $error("compute ended without a final result");

endmodule

bind matrix_multiply_transposed_b mmtb_checker u_mmtb_checker (.*);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_multiply_transposed_b. It keeps its own copy
// of the A and transposed-B stores and of the size registers. From these it
// works out every C element that a compute transaction should produce, and
// compares each result with that list, in order. Directed tests cover signed
// extremes, zero and oversized dimensions, a full 8x8x8 product and a long
// output stall. Random phases with random sizes and content follow.
// ----------------------------------------------------------------------------
module testbench;
    import mmtb_pkg::*;

    localparam int MAX_DIM = MMTB_MAX_DIM;
    // The block ignores this kind; the bench uses it as noise.
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Stop sending random transactions once this many loads and computes are accepted.
    localparam int unsigned ITEM_TARGET    = 270;
    // Config writes wait this long after the last expected element, because a
    // compute of an empty matrix produces nothing that could tell us when it is
    // done.
    localparam int unsigned SETTLE_CYCLES  = 720;
    localparam int unsigned HOLD_CYCLES    = 300;
    // The longest quiet stretch in a correct run is a settle period or the hold.
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    matrix_multiply_transposed_b #(
        .MAX_DIM(MAX_DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench copy of the block's state. The written flags make sure that a
    // compute never reads an entry that has not been loaded.
    logic signed [ELEM_W-1:0] a_mirror  [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] bt_mirror [MAX_DIM*MAX_DIM];
    bit                       a_loaded  [MAX_DIM*MAX_DIM];
    bit                       bt_loaded [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]         dim_shadow [3];

    // C elements predicted but not yet seen on the output, oldest first.
    t_out        c_elements_due[$];
    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    // Set in the last part of the run: no random gaps on either side.
    bit          calm         = 1'b0;
    // Asks the output side for one long stall.
    bit          hold_req     = 1'b0;

    function automatic int unsigned dim_of(logic [CFG_IDX_W-1:0] idx);
        return (dim_shadow[idx] > MAX_DIM) ? MAX_DIM : dim_shadow[idx];
    endfunction

    // Apply one accepted transaction to the mirror. A compute appends the
    // whole C matrix, row-major, to the list of elements due.
    function automatic void mirror_item(t_in item);
        int unsigned addr;
        int unsigned nr;
        int unsigned nc;
        int unsigned nk;
        longint      acc;
        t_out        elem;
        addr = {item.row_index, item.col_index};
        case (item.kind)
            KIND_LOAD_A: begin
                a_mirror[addr] = item.element;
                a_loaded[addr] = 1'b1;
            end
            KIND_LOAD_BT: begin
                bt_mirror[addr] = item.element;
                bt_loaded[addr] = 1'b1;
            end
            KIND_COMPUTE: begin
                nr = dim_of(CFG_ROWS_A);
                nc = dim_of(CFG_COLS_RESULT);
                nk = dim_of(CFG_INNER_LEN);
                for (int unsigned i = 0; i < nr; i++) begin
                    for (int unsigned j = 0; j < nc; j++) begin
                        acc = 0;
                        for (int unsigned k = 0; k < nk; k++) begin
                            acc += longint'(a_mirror[i*MAX_DIM + k])
                                 * longint'(bt_mirror[j*MAX_DIM + k]);
                        end
                        elem.product = acc[SUM_W-1:0];
                        elem.last    = (i == nr - 1) && (j == nc - 1);
                        c_elements_due.push_back(elem);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic logic [ELEM_W-1:0] rand_element();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return ELEM_W'($urandom);
    endfunction

    // Random pick between the two load kinds.
    function automatic logic [1:0] rand_load_kind();
        return ($urandom_range(0, 1) == 0) ? KIND_LOAD_A : KIND_LOAD_BT;
    endfunction

    function automatic t_in make_item(logic [1:0] kind, int unsigned row, int unsigned col,
                                      logic [ELEM_W-1:0] value);
        t_in item;
        item.kind      = kind;
        item.row_index = IDX_W'(row);
        item.col_index = IDX_W'(col);
        item.element   = value;
        return item;
    endfunction

    // Compute transactions carry random values in the fields the block ignores.
    function automatic t_in compute_item();
        return make_item(KIND_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                         ELEM_W'($urandom));
    endfunction

    // One input transaction. The payload changes only at a falling edge and
    // stays put until the block takes it. Valid is left high afterwards so
    // that back-to-back transactions follow without a gap; release_input
    // drops it.
    task automatic send_item(t_in item);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        mirror_item(item);
        if (item.kind != KIND_IGNORED) begin
            items_sent++;
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait until every predicted element has come out, then let the block
    // finish whatever it may still be doing.
    task automatic settle();
        release_input();
        while (c_elements_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        dim_shadow[idx] = value;
    endtask

    // Change the sizes; only the registers picked by the mask are written.
    task automatic set_dims(logic [2:0] mask, logic [DIM_W-1:0] rows,
                            logic [DIM_W-1:0] cols, logic [DIM_W-1:0] inner);
        settle();
        if (mask[0]) write_reg(CFG_ROWS_A, rows);
        if (mask[1]) write_reg(CFG_COLS_RESULT, cols);
        if (mask[2]) write_reg(CFG_INNER_LEN, inner);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Load every entry that the next compute will read and that was never
    // written, so no result ever depends on uninitialized store contents.
    task automatic fill_operands();
        int unsigned nr;
        int unsigned nc;
        int unsigned nk;
        nr = dim_of(CFG_ROWS_A);
        nc = dim_of(CFG_COLS_RESULT);
        nk = dim_of(CFG_INNER_LEN);
        for (int unsigned k = 0; k < nk; k++) begin
            for (int unsigned i = 0; i < nr; i++) begin
                if (!a_loaded[i*MAX_DIM + k]) begin
                    send_item(make_item(KIND_LOAD_A, i, k, rand_element()));
                end
            end
            for (int unsigned j = 0; j < nc; j++) begin
                if (!bt_loaded[j*MAX_DIM + k]) begin
                    send_item(make_item(KIND_LOAD_BT, j, k, rand_element()));
                end
            end
        end
    endtask

    // Random pick for one size register: mostly small, sometimes zero,
    // sometimes full size, sometimes above the maximum.
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r <= 12) return DIM_W'($urandom_range(1, 3));
        if (r <= 16) return DIM_W'($urandom_range(4, 8));
        return DIM_W'($urandom_range(9, 15));
    endfunction

    // Largest positive and negative values, including the most negative
    // squared, plus a load at the last row and inner position, an ignored
    // kind, and a compute.
    task automatic test_signed_extremes();
        set_dims(3'b111, 2, 2, 2);
        send_item(make_item(KIND_LOAD_A, 0, 0, 16'h7FFF));
        send_item(make_item(KIND_LOAD_A, 0, 1, 16'h8000));
        send_item(make_item(KIND_LOAD_A, 1, 0, 16'h8000));
        send_item(make_item(KIND_LOAD_A, 1, 1, 16'hFFFF));
        send_item(make_item(KIND_LOAD_BT, 0, 0, 16'h8000));
        send_item(make_item(KIND_LOAD_BT, 0, 1, 16'h8000));
        send_item(make_item(KIND_LOAD_BT, 1, 0, 16'h7FFF));
        send_item(make_item(KIND_LOAD_BT, 1, 1, 16'h0001));
        send_item(make_item(KIND_LOAD_A, 7, 7, 16'h5A5A));
        send_item(make_item(KIND_LOAD_BT, 7, 7, 16'hA5A5));
        send_item(make_item(KIND_IGNORED, 7, 7, 16'hFFFF));
        send_item(compute_item());
    endtask

    // A zero row or column count yields no elements at all; a zero inner
    // length yields a matrix of zeros.
    task automatic test_zero_dims();
        set_dims(3'b001, 0, 0, 0);
        send_item(compute_item());
        set_dims(3'b011, 2, 0, 0);
        send_item(compute_item());
        set_dims(3'b110, 0, 2, 0);
        send_item(compute_item());
        set_dims(3'b100, 0, 0, 1);
        send_item(compute_item());
    endtask

    // Values above the maximum size behave as the maximum; then the same
    // full-size product with the registers at exactly the maximum.
    task automatic test_full_size();
        set_dims(3'b111, 15, 9, 12);
        fill_operands();
        send_item(compute_item());
        set_dims(3'b111, 8, 8, 8);
        send_item(compute_item());
    endtask

    // The output stalls for a long stretch while loads and another compute
    // queue up behind a compute in progress.
    task automatic test_backpressure();
        set_dims(3'b111, 4, 4, 4);
        hold_req = 1'b1;
        send_item(compute_item());
        for (int n = 0; n < 6; n++) begin
            send_item(make_item(rand_load_kind(), $urandom_range(0, 3),
                                $urandom_range(0, 3), rand_element()));
        end
        send_item(compute_item());
    endtask

    // Phases of random sizes; each phase loads random content, throws in
    // an occasional ignored transaction and ends with a compute.
    task automatic test_random_mix();
        int unsigned n_ops;
        int unsigned pick;
        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= ITEM_TARGET * 4 / 5);
            set_dims(3'($urandom_range(1, 7)), pick_dim(), pick_dim(), pick_dim());
            n_ops = $urandom_range(3, 10);
            for (int unsigned n = 0; n < n_ops; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_item(make_item(KIND_IGNORED, $urandom_range(0, 7),
                                        $urandom_range(0, 7), ELEM_W'($urandom)));
                end else if (pick <= 6) begin
                    send_item(make_item(rand_load_kind(), $urandom_range(0, 7),
                                        $urandom_range(0, 7), rand_element()));
                end else begin
                    fill_operands();
                    send_item(compute_item());
                end
            end
            fill_operands();
            send_item(compute_item());
        end
    endtask

    // Output side: random stall bursts, none once the run is calm, and one
    // long stall on request.
    initial begin
        int unsigned burst_left;
        burst_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (burst_left != 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(0, 4);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every output transaction is checked against the oldest predicted element.
    always @(posedge i_clk) begin
        t_out due;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (c_elements_due.size() == 0) begin
                report_mismatch($sformatf("unexpected element product=%0d last=%0b",
                                          o_out.product, o_out.last));
            end else begin
                due = c_elements_due.pop_front();
                if (o_out.product !== due.product || o_out.last !== due.last) begin
                    report_mismatch($sformatf(
                        "expected product=%0d last=%0b, got product=%0d last=%0b",
                        due.product, due.last, o_out.product, o_out.last));
                end
            end
        end
    end

    // Watchdog: any transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[matrix_multiply_transposed_b] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int n = 0; n < 3; n++) begin
            dim_shadow[n] = DIM_W'(MAX_DIM);
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_signed_extremes();
        test_zero_dims();
        test_full_size();
        test_backpressure();
        test_random_mix();
        settle();

        if (mismatches == 0 && c_elements_due.size() == 0) begin
            $display("[matrix_multiply_transposed_b] OK");
        end else begin
            $display("[matrix_multiply_transposed_b] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/mmtb_pkg.sv
src/mmtb_ctrl.sv
src/mmtb_datapath.sv
src/matrix_multiply_transposed_b.sv
src/mmtb_checker.sv
sim/testbench.sv
